// ===== rtl/mrpt_pkg.sv =====
// shared constants and helpers for the primality tester
package mrpt_pkg;
  localparam int VALUE_WIDTH = 64;
  localparam int BASE_COUNT = 12;
  localparam int BIT_IDX_W = $clog2(VALUE_WIDTH);
  localparam int BASE_IDX_W = 4;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // fixed witness bases
  function automatic logic [5:0] witness_base(input logic [BASE_IDX_W-1:0] idx);
    logic [5:0] b;
    case (idx)
      4'd0: b = 6'd2;
      4'd1: b = 6'd3;
      4'd2: b = 6'd5;
      4'd3: b = 6'd7;
      4'd4: b = 6'd11;
      4'd5: b = 6'd13;
      4'd6: b = 6'd17;
      4'd7: b = 6'd19;
      4'd8: b = 6'd23;
      4'd9: b = 6'd29;
      4'd10: b = 6'd31;
      4'd11: b = 6'd37;
      default: b = 6'd2;
    endcase
    return b;
  endfunction

  // (r + a) mod m with r, a < m
  function automatic value_t add_mod(input value_t r, input value_t a, input value_t m);
    value_t room;
    room = m - a;
    if (r >= room) return r - room;
    return r + a;
  endfunction
endpackage

// ===== rtl/mrpt_mulmod.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle
module mrpt_mulmod (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  mrpt_pkg::value_t a,
  input  mrpt_pkg::value_t b,
  input  mrpt_pkg::value_t m,
  output logic            done,
  output mrpt_pkg::value_t prod
);
  import mrpt_pkg::*;

  logic            active;
  logic [BIT_IDX_W-1:0] cnt;
  value_t          mult;
  value_t          acc;
  value_t          acc_dbl;
  value_t          acc_next;

  always_comb begin
    acc_dbl = add_mod(acc, acc, m);
    acc_next = mult[VALUE_WIDTH-1] ? add_mod(acc_dbl, a, m) : acc_dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt <= '0;
        acc <= '0;
        mult <= b;
      end else if (active) begin
        acc <= acc_next;
        mult <= mult << 1;
        cnt <= cnt + 1'b1;
        if (cnt == BIT_IDX_W'(VALUE_WIDTH - 1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_done_after_active: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(active))
    else $error("done without work");
  a_no_go_busy: assert property (@(posedge clk) disable iff (rst)
    active && !done |-> !go || cnt == '0)
    else $error("restart mid product");
endmodule

// ===== rtl/miller_rabin_prime_test.sv =====
// deterministic miller-rabin primality test over 64-bit candidates
// trivial candidates (below 2, or even) skip the bases and go straight to S_FINISH
// throughput: one candidate at a time; busy stays high until the strobe beat
// each modular product is a bit-serial add-double pass over all 64 multiplier bits in mrpt_mulmod
// reset: synchronous active-high rst returns the sequencer to idle, no result pending
// the result beat is shown for one cycle with done; the receiver cannot stall it
module miller_rabin_prime_test (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mrpt_pkg::value_t     candidate,
  output logic                 busy,
  output logic                 done,
  output logic                 is_prime_flag
);
  import mrpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ODD, S_BASE, S_REDUCE, S_EXP_BIT, S_EXP_MUL, S_EXP_SQR,
    S_CHAIN, S_CHAIN_SQR, S_FINISH
  } state_t;

  state_t state;
  value_t n;          // candidate under test
  value_t n1;         // n - 1
  value_t d;          // odd part of n - 1
  value_t e;          // exponent bits still to use
  value_t t;          // exponent tracked through the squaring chain
  value_t acc;        // running power
  value_t x;          // running base square
  value_t y;
  logic [BASE_IDX_W-1:0] base_idx;

  // shared serial multiplier
  logic   mm_go;
  value_t mm_a, mm_b;
  logic   mm_done;
  value_t mm_prod;

  mrpt_mulmod u_mul (
    .clk(clk), .rst(rst), .go(mm_go), .a(mm_a), .b(mm_b), .m(n),
    .done(mm_done), .prod(mm_prod)
  );

  value_t base_val;
  assign base_val = value_t'(witness_base(base_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      is_prime_flag <= 1'b0;
      mm_go <= 1'b0;
      base_idx <= '0;
    end else begin
      done <= 1'b0;
      mm_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n <= candidate;
            n1 <= candidate - 1'b1;
            d <= (candidate - 1'b1) >> 1;
            busy <= 1'b1;
            base_idx <= '0;
            if (candidate == value_t'(2)) begin
              is_prime_flag <= 1'b1;
              state <= S_FINISH;
            end else if (candidate < value_t'(2) || !candidate[0]) begin
              is_prime_flag <= 1'b0;
              state <= S_FINISH;
            end else begin
              state <= S_ODD;
            end
          end
        end
        // strip factors of two, one per cycle
        S_ODD: begin
          if (d[0]) state <= S_BASE;
          else d <= d >> 1;
        end
        S_BASE: begin
          if (base_idx == BASE_IDX_W'(BASE_COUNT)) begin
            is_prime_flag <= 1'b1;
            state <= S_FINISH;
          end else if (base_val == n) begin
            is_prime_flag <= 1'b1;
            state <= S_FINISH;
          end else begin
            e <= d;
            t <= d;
            acc <= (n == value_t'(1)) ? '0 : value_t'(1);
            x <= base_val;
            state <= S_REDUCE;
          end
        end
        // base below 64 only exceeds n for small n; subtract until reduced
        S_REDUCE: begin
          if (x >= n) x <= x - n;
          else state <= S_EXP_BIT;
        end
        S_EXP_BIT: begin
          if (e == '0) begin
            y <= acc;
            state <= S_CHAIN;
          end else if (e[0]) begin
            mm_a <= acc; mm_b <= x; mm_go <= 1'b1;
            state <= S_EXP_MUL;
          end else begin
            mm_a <= x; mm_b <= x; mm_go <= 1'b1;
            state <= S_EXP_SQR;
          end
        end
        S_EXP_MUL: begin
          if (mm_done) begin
            acc <= mm_prod;
            mm_a <= x; mm_b <= x; mm_go <= 1'b1;
            state <= S_EXP_SQR;
          end
        end
        S_EXP_SQR: begin
          if (mm_done) begin
            x <= mm_prod;
            e <= e >> 1;
            state <= S_EXP_BIT;
          end
        end
        S_CHAIN: begin
          if (t != n1 && y != value_t'(1) && y != n1) begin
            mm_a <= y; mm_b <= y; mm_go <= 1'b1;
            state <= S_CHAIN_SQR;
          end else if (y != n1 && !t[0]) begin
            is_prime_flag <= 1'b0;
            state <= S_FINISH;
          end else begin
            base_idx <= base_idx + 1'b1;
            state <= S_BASE;
          end
        end
        S_CHAIN_SQR: begin
          if (mm_done) begin
            y <= mm_prod;
            t <= t << 1;
            state <= S_CHAIN;
          end
        end
        S_FINISH: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy during result beat");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double result");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accept without busy");
endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the 64-bit miller-rabin primality tester
`timescale 1ns / 100ps

module tb_top;
  import mrpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic   clk;
  logic   rst;
  logic   start;
  value_t candidate;
  logic   busy;
  logic   done;
  logic   is_prime_flag;

  miller_rabin_prime_test DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .candidate(candidate),
    .busy(busy),
    .done(done),
    .is_prime_flag(is_prime_flag)
  );

  value_t pending_candidates[$];   // beats waiting to be offered
  logic   expected_flags[$];       // verdicts of accepted candidates, oldest first
  value_t expected_inputs[$];      // candidate behind each verdict, for messages
  int     errors;
  int     idle_cycles;
  int     gap_left;
  logic   took_beat;

  // witness bases in test order
  localparam logic [5:0] BASES [12] = '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
                                        6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37};

  // exact (a * b) mod m via a full 128-bit product
  function automatic value_t modmul(value_t a, value_t b, value_t m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return value_t'(prod % {64'd0, m});
  endfunction

  function automatic value_t modpow(value_t b, value_t e, value_t m);
    value_t acc;
    value_t x;
    acc = 64'd1 % m;
    x = b % m;
    while (e != 0) begin
      if (e[0]) acc = modmul(acc, x, m);
      x = modmul(x, x, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // predicted primality verdict for one candidate
  function automatic logic primality_of(value_t n);
    value_t nm1;
    value_t odd_part;
    value_t t;
    value_t y;
    value_t a;
    if (n == 2) return 1'b1;
    if (n < 2 || !n[0]) return 1'b0;
    nm1 = n - 1;
    odd_part = nm1 >> 1;
    while (!odd_part[0]) odd_part = odd_part >> 1;
    for (int i = 0; i < BASE_COUNT && i < 12; i++) begin
      a = value_t'(BASES[i]);
      if (a == n) return 1'b1;  // base equal to candidate passes it
      t = odd_part;
      y = modpow(a, t, n);
      while (t != nm1 && y != 1 && y != nm1) begin
        y = modmul(y, y, n);
        t = t << 1;
      end
      if (y != nm1 && !t[0]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly short gaps, sometimes none, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver: inputs move on the falling edge only
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      candidate <= '0;
      gap_left <= 0;
    end else if (!start || took_beat) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_candidates.size() != 0) begin
        candidate <= pending_candidates.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: accepts and result beats sampled on the rising edge
  always @(posedge clk) begin
    took_beat <= !rst && start && !busy;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        expected_flags.push_back(primality_of(candidate));
        expected_inputs.push_back(candidate);
      end
      if (done) begin
        if (expected_flags.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual flag %0b",
                   $time, is_prime_flag);
          errors <= errors + 1;
        end else begin
          logic   want;
          value_t n;
          want = expected_flags.pop_front();
          n = expected_inputs.pop_front();
          if (is_prime_flag !== want) begin
            $display("%0t: candidate %0d flag mismatch, expected %0b, actual %0b",
                     $time, n, want, is_prime_flag);
            errors <= errors + 1;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, expected_flags.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    value_t v;
    int     width;
    errors = 0;
    idle_cycles = 0;
    took_beat = 1'b0;
    start = 1'b0;
    candidate = '0;
    gap_left = 0;
    rst = 1'b1;

    // directed: trivial cases, bases themselves, pseudoprimes, range extremes
    pending_candidates.push_back(64'd0);
    pending_candidates.push_back(64'd1);
    pending_candidates.push_back(64'd2);
    pending_candidates.push_back(64'd3);
    pending_candidates.push_back(64'd4);
    pending_candidates.push_back(64'd9);
    pending_candidates.push_back(64'd37);                   // largest base equals candidate
    pending_candidates.push_back(64'd31);
    pending_candidates.push_back(64'd41);                   // smallest prime above the largest base
    pending_candidates.push_back(64'd561);                  // carmichael number
    pending_candidates.push_back(64'd2047);                 // strong liar for base 2
    pending_candidates.push_back(64'd3215031751);           // strong liar for bases 2..7
    pending_candidates.push_back(64'd3825123056546413051);  // fools bases 2..23
    pending_candidates.push_back(64'hFFFF_FFFF_FFFF_FFC5);  // largest 64-bit prime
    pending_candidates.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_candidates.push_back(64'hFFFF_FFFF_FFFF_FFFE);  // large even
    pending_candidates.push_back(64'h8000_0000_0000_0000);
    pending_candidates.push_back(64'd4294967291);           // largest 32-bit prime
    pending_candidates.push_back(64'd65537);

    // random: mostly odd values of varied width, where primes are common when small
    for (int i = 0; i < 131; i++) begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: v[0] = 1'b0;                                     // even noise
        1, 2: v = v;                                        // full width
        default: begin
          width = $urandom_range(3, 40);
          v = (v & ((64'd1 << width) - 1)) | 64'd1;
        end
      endcase
      pending_candidates.push_back(v);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (pending_candidates.size() == 0 && !start && expected_flags.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
